[hw/rtl/tdc_pkg.sv]
package tdc_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ROOT_STEPS   = 16;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned VEC_W        = 36;
  localparam int unsigned ACC_W        = 25;

  localparam logic signed [15:0] RIGHT_ANGLE  = 16'sd11520;
  localparam logic [11:0]        CODE_FORWARD = 12'h935;
  localparam logic [11:0]        CODE_NEUTRAL = 12'hD00;
  localparam logic [11:0]        CODE_REVERSE = 12'hFFF;
  localparam logic [6:0]         LIMIT_RESET  = 7'd30;

  typedef enum logic [2:0] {
    LANE_IDLE,
    LANE_SQB,
    LANE_SQC,
    LANE_ROOT,
    LANE_ROT,
    LANE_DONE
  } lane_state_e;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] angle;
  } lane_stat_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [21:0] atan_entry(input logic [CNT_W-1:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/tilt_drive_classifier.sv]
// Tilt drive classifier.
// Input stream: one beat per accelerometer sample. tdata carries accel_x,
// accel_y, accel_z (signed 16 bit, 16384 per g); tuser selects drive (0)
// or capture of the zero reference (1).
// Two identical lanes find the x and z tilt (square root plus iterative
// CORDIC); a merge stage applies the reference, picks DAC codes and alarm.
// Output stream: one beat per sample with both DAC codes, the alarm flag
// and the relative tilts in 1/128 degree.
// Each sample passes the squaring on the lane multiplier, the square root,
// the CORDIC rotation and the merge register on its way to output tvalid.
// One sample is in flight at a time; the next sample is taken while a
// finished result still waits in the output register.
// A stalled receiver holds the output beat; a finished lane result waits
// until the output register frees up.
// Reset: limit 30 degrees, reference angles zero, stream idle.
// The cfg channel writes angle_limit and is always ready.
module tilt_drive_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,     // angle_limit
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i, // accel_x, accel_y, accel_z
  input  logic        s_axis_tuser_i, // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // straight_code, sideways_code, over_tilt_alarm, x_tilt, z_tilt, pad
  output logic [63:0] m_axis_tdata_o
);
  import tdc_pkg::*;

  logic       busy_q, op_q, out_valid_q;
  logic [6:0] limit_q;
  logic       accept, load;
  lane_ctrl_t ctrl;
  lane_stat_t x_stat, z_stat;
  logic signed [15:0] ax, ay, az;

  logic [11:0]        straight, sideways;
  logic               alarm;
  logic signed [15:0] x_tilt, z_tilt;

  assign ax = $signed(s_axis_tdata_i[15:0]);
  assign ay = $signed(s_axis_tdata_i[31:16]);
  assign az = $signed(s_axis_tdata_i[47:32]);

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load = x_stat.done && z_stat.done && (!out_valid_q || m_axis_tready_i);

  assign ctrl.start = accept;
  assign ctrl.ack   = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      op_q        <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= LIMIT_RESET;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (accept) begin
        busy_q <= 1'b1;
        op_q   <= s_axis_tuser_i;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  tdc_lane u_lane_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .a_i    (ax),
    .b_i    (ay),
    .c_i    (az),
    .stat_o (x_stat)
  );

  tdc_lane u_lane_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .a_i    (az),
    .b_i    (ax),
    .c_i    (ay),
    .stat_o (z_stat)
  );

  tdc_merge u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (load),
    .capture_i         (op_q),
    .limit_i           (limit_q),
    .x_angle_i         (x_stat.angle),
    .z_angle_i         (z_stat.angle),
    .straight_code_o   (straight),
    .sideways_code_o   (sideways),
    .over_tilt_alarm_o (alarm),
    .x_tilt_o          (x_tilt),
    .z_tilt_o          (z_tilt)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, z_tilt, x_tilt, alarm, sideways, straight};

  // both lanes run in lockstep
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_stat.done == z_stat.done) else $error("lanes out of step");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> busy_q) else $error("result without a sample in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !x_stat.done) else $error("sample not taken up");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid_o) else $error("result beat lost");

endmodule

[hw/rtl/tdc_lane.sv]
module tdc_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdc_pkg::lane_ctrl_t ctrl_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  input  logic signed [15:0] c_i,
  output tdc_pkg::lane_stat_t stat_o
);
  import tdc_pkg::*;

  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
  localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(CORDIC_STEPS - 1);

  lane_state_e state_q, state_d;

  logic signed [15:0]       a_q, b_q, c_q;
  logic [31:0]              rad_q, root_q, bit_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [VEC_W-1:0]  x_q, y_q;
  logic signed [ACC_W-1:0]  z_q;
  logic                     zero_q;

  logic [31:0]              sum, rad_step, root_step;
  logic                     take;
  logic signed [31:0]       sq;
  logic signed [VEC_W-1:0]  dx, dy;
  logic signed [ACC_W-1:0]  arc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [15:0]       q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LANE_IDLE: if (ctrl_i.start) state_d = LANE_SQB;
      LANE_SQB:  state_d = LANE_SQC;
      LANE_SQC:  state_d = LANE_ROOT;
      LANE_ROOT: if (cnt_q == ROOT_LAST) state_d = LANE_ROT;
      LANE_ROT:  if (cnt_q == ROT_LAST) state_d = LANE_DONE;
      LANE_DONE: if (ctrl_i.ack) state_d = LANE_IDLE;
      default:   state_d = LANE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LANE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // one multiplier, shared by both squares
  assign sq = (state_q == LANE_SQB) ? b_q * b_q : c_q * c_q;

  // restoring square root, one result bit per cycle
  assign sum       = root_q + bit_q;
  assign take      = rad_q >= sum;
  assign rad_step  = take ? rad_q - sum : rad_q;
  assign root_step = take ? (root_q >> 1) + bit_q : root_q >> 1;

  assign dx  = y_q >>> cnt_q;
  assign dy  = x_q >>> cnt_q;
  assign arc = ACC_W'(atan_entry(cnt_q));

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      LANE_IDLE: begin
        a_q <= a_i;
        b_q <= b_i;
        c_q <= c_i;
      end
      LANE_SQB: rad_q <= 32'(sq);
      LANE_SQC: begin
        rad_q  <= rad_q + 32'(sq);
        root_q <= '0;
        bit_q  <= 32'h4000_0000;
        cnt_q  <= '0;
      end
      LANE_ROOT: begin
        rad_q  <= rad_step;
        root_q <= root_step;
        bit_q  <= bit_q >> 2;
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == ROOT_LAST) begin
          cnt_q  <= '0;
          x_q    <= {4'b0, root_step[15:0], 16'b0};
          y_q    <= {{(VEC_W-32){a_q[15]}}, a_q, 16'b0};
          z_q    <= '0;
          zero_q <= (root_step[15:0] == 16'd0) && (a_q == 16'sd0);
        end
      end
      LANE_ROT: begin
        cnt_q <= cnt_q + 1'b1;
        if (!y_q[VEC_W-1]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + arc;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - arc;
        end
      end
      default: ;
    endcase
  end

  // round to 1/128 degree, saturate, shift by a right angle
  always_comb begin
    rnd = (z_q + ACC_W'(256)) >>> 9;
    if (rnd > ACC_W'(RIGHT_ANGLE)) begin
      q = RIGHT_ANGLE;
    end else if (rnd < -ACC_W'(RIGHT_ANGLE)) begin
      q = -RIGHT_ANGLE;
    end else begin
      q = rnd[15:0];
    end
  end

  always_comb begin
    stat_o.done  = (state_q == LANE_DONE);
    stat_o.angle = zero_q ? -RIGHT_ANGLE : q - RIGHT_ANGLE;
  end

endmodule

[hw/rtl/tdc_merge.sv]
module tdc_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               capture_i,
  input  logic [6:0]         limit_i,
  input  logic signed [15:0] x_angle_i,
  input  logic signed [15:0] z_angle_i,
  output logic [11:0]        straight_code_o,
  output logic [11:0]        sideways_code_o,
  output logic               over_tilt_alarm_o,
  output logic signed [15:0] x_tilt_o,
  output logic signed [15:0] z_tilt_o
);
  import tdc_pkg::*;

  logic signed [15:0] zero_x_q, zero_z_q;
  logic signed [16:0] xt, zt, lim, ax, az, amax;
  logic [15:0]        alarm_lim;

  function automatic logic [11:0] code_of(input logic signed [16:0] t,
                                          input logic signed [16:0] l);
    logic [11:0] c;
    if (t >= l) begin
      c = CODE_FORWARD;
    end else if (t <= -l) begin
      c = CODE_REVERSE;
    end else begin
      c = CODE_NEUTRAL;
    end
    return c;
  endfunction

  // capture re-references first, so its own result reads zero tilt
  always_comb begin
    xt   = capture_i ? 17'sd0 : 17'(x_angle_i) - 17'(zero_x_q);
    zt   = capture_i ? 17'sd0 : 17'(z_angle_i) - 17'(zero_z_q);
    lim  = $signed({3'b0, limit_i, 7'b0});
    ax   = xt[16] ? -xt : xt;
    az   = zt[16] ? -zt : zt;
    amax = (az > ax) ? az : ax;
    alarm_lim = 16'({limit_i, 7'b0}) + 16'({limit_i, 6'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_x_q <= '0;
      zero_z_q <= '0;
    end else if (load_i && capture_i) begin
      zero_x_q <= x_angle_i;
      zero_z_q <= z_angle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      straight_code_o   <= code_of(xt, lim);
      sideways_code_o   <= code_of(zt, lim);
      over_tilt_alarm_o <= amax[15:0] > alarm_lim;
      x_tilt_o          <= xt[15:0];
      z_tilt_o          <= zt[15:0];
    end
  end

endmodule

[bench/tilt_drive_checker.sv]
module tilt_drive_checker #(
  parameter bit CAPTURE_OP = 1'b1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,    // accel_x, accel_y, accel_z
  input  logic        s_tuser_i,    // operation
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,    // straight, sideways, alarm, x_tilt, z_tilt
  output int          fail_count_o,
  output int          pending_o,
  output int          beats_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tdc_pkg::*;

  // packed from the top bit down, so straight lands in the lowest bits
  typedef struct packed {
    logic signed [15:0] z_tilt;
    logic signed [15:0] x_tilt;
    logic               alarm;
    logic [11:0]        sideways;
    logic [11:0]        straight;
  } drive_cmd_t;

  drive_cmd_t  cmd_q[$];
  logic [6:0]  limit_deg;
  logic signed [15:0] ref_x, ref_z;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // absolute tilt of axis a against the b/c plane, 1/128 degree, minus 90
  function automatic logic signed [15:0] tilt_of(int a, int b, int c);
    longint h, x, y, z, dx, dy, q;
    h = longint'(isqrt(longint'(b) * b + longint'(c) * c));
    if (h == 0 && a == 0) return -RIGHT_ANGLE;
    x = h * 65536;
    y = longint'(a) * 65536;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(atan_entry(CNT_W'(i)));
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(atan_entry(CNT_W'(i)));
      end
    end
    q = (z + 256) >>> 9;
    if (q > 11520) q = 11520;
    if (q < -11520) q = -11520;
    return 16'(q - 11520);
  endfunction

  function automatic logic [11:0] dac_level(int t, int lim);
    if (t >= lim) return CODE_FORWARD;
    if (t <= -lim) return CODE_REVERSE;
    return CODE_NEUTRAL;
  endfunction

  function automatic drive_cmd_t predict_cmd(logic [47:0] d, logic op);
    drive_cmd_t c;
    int ax, ay, az, xt, zt, mx, mz;
    logic signed [15:0] xa, za;
    ax = int'($signed(d[15:0]));
    ay = int'($signed(d[31:16]));
    az = int'($signed(d[47:32]));
    xa = tilt_of(ax, ay, az);
    za = tilt_of(az, ax, ay);
    if (op == CAPTURE_OP) begin
      ref_x = xa;
      ref_z = za;
    end
    xt = int'(xa) - int'(ref_x);
    zt = int'(za) - int'(ref_z);
    mx = xt < 0 ? -xt : xt;
    mz = zt < 0 ? -zt : zt;
    if (mz > mx) mx = mz;
    c.straight = dac_level(xt, int'(limit_deg) * 128);
    c.sideways = dac_level(zt, int'(limit_deg) * 128);
    c.alarm    = mx > int'(limit_deg) * 192;
    c.x_tilt   = 16'(xt);
    c.z_tilt   = 16'(zt);
    return c;
  endfunction

  task automatic report(string fld, longint e, longint g);
    $display("%0t ns: %s mismatch, expected %0d got %0d", $time, fld, e, g);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drive_cmd_t e, g;
    if (!rst_ni) begin
      limit_deg = LIMIT_RESET;
      ref_x = '0;
      ref_z = '0;
      cmd_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) limit_deg = cfg_data_i;
      if (s_tvalid_i && s_tready_i) cmd_q.push_back(predict_cmd(s_tdata_i, s_tuser_i));
      if (m_tvalid_i && m_tready_i) begin
        g = m_tdata_i[56:0];
        beats_checked_o++;
        if (cmd_q.size() == 0) begin
          $display("%0t ns: unexpected output beat %h", $time, m_tdata_i);
          fail_count_o++;
        end else begin
          e = cmd_q.pop_front();
          if (e.straight != g.straight) report("straight_code", e.straight, g.straight);
          if (e.sideways != g.sideways) report("sideways_code", e.sideways, g.sideways);
          if (e.alarm != g.alarm) report("over_tilt_alarm", e.alarm, g.alarm);
          if (e.x_tilt != g.x_tilt) report("x_tilt", e.x_tilt, g.x_tilt);
          if (e.z_tilt != g.z_tilt) report("z_tilt", e.z_tilt, g.z_tilt);
        end
      end
    end
    pending_o = cmd_q.size();
  end

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    beats_checked_o = 0;
  end

endmodule

[bench/tilt_drive_classifier_tb.sv]
module tilt_drive_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit OP_DRIVE   = 1'b0;
  localparam bit OP_CAPTURE = 1'b1;
  localparam int STALL_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // accel_x, accel_y, accel_z
  logic        s_tuser = 1'b0; // operation
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [63:0] m_tdata;        // straight, sideways, alarm, x_tilt, z_tilt, pad

  logic s_rdy_seen, cfg_rdy_seen;
  bit   quiet = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   fail_count, pending, beats_checked;
  int   n_samples = 0, n_captures = 0, n_limits = 0;

  always #1 clk_i = ~clk_i;

  tilt_drive_classifier i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  tilt_drive_checker #(.CAPTURE_OP(OP_CAPTURE)) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .s_tuser_i       (s_tuser),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .beats_checked_o (beats_checked)
  );

  // ready as it stands at the coming rising edge
  always @(negedge clk_i) begin
    s_rdy_seen   = s_tready;
    cfg_rdy_seen = cfg_ready;
  end

  // receiver back-pressure in random bursts, none while quiet
  always @(posedge clk_i) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_sample(bit op, logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {az, ay, ax};
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_rdy_seen);
    n_samples++;
    if (op == OP_CAPTURE) n_captures++;
  endtask

  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    // let the checker log the last accepted beat before looking at pending
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [6:0] deg);
    cfg_valid <= 1'b1;
    cfg_data  <= deg;
    do @(posedge clk_i); while (!cfg_rdy_seen);
    cfg_valid <= 1'b0;
    n_limits++;
  endtask

  function automatic logic [15:0] axis_value(int mode);
    case (mode)
      0:       return 16'($urandom_range(0, 32768) - 16384);
      1:       return 16'($urandom);
      default: return 16'($urandom_range(0, 64) - 32);
    endcase
  endfunction

  task automatic random_samples(int count);
    int mode;
    bit op;
    for (int k = 0; k < count; k++) begin
      mode = $urandom_range(0, 99) < 70 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
      op = ($urandom_range(0, 99) < 8) ? OP_CAPTURE : OP_DRIVE;
      push_sample(op, axis_value(mode), axis_value(mode), axis_value(mode));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero vector, pure axes, full-scale corners, then tilt against a captured reference
    push_sample(OP_DRIVE, 16'h0000, 16'h0000, 16'h0000);
    push_sample(OP_DRIVE, 16'd16384, 16'h0000, 16'h0000);
    push_sample(OP_DRIVE, 16'h0000, 16'd16384, 16'h0000);
    push_sample(OP_DRIVE, 16'h0000, 16'h0000, 16'd16384);
    push_sample(OP_DRIVE, -16'sd16384, 16'h0000, 16'h0000);
    push_sample(OP_DRIVE, 16'h0000, 16'h0000, -16'sd16384);
    push_sample(OP_DRIVE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_sample(OP_DRIVE, 16'h8000, 16'h8000, 16'h8000);
    push_sample(OP_DRIVE, 16'h7FFF, 16'h8000, 16'h0001);
    push_sample(OP_DRIVE, 16'h8000, 16'h0000, 16'h7FFF);
    push_sample(OP_DRIVE, 16'h0001, 16'h0000, 16'h0000);
    push_sample(OP_DRIVE, 16'hFFFF, 16'h0000, 16'h0000);
    push_sample(OP_CAPTURE, 16'h0000, 16'h0000, 16'h0000);
    push_sample(OP_DRIVE, 16'd16384, 16'h0000, 16'h0000);
    push_sample(OP_CAPTURE, 16'd2000, 16'd500, 16'd16000);
    push_sample(OP_DRIVE, 16'd2000, 16'd500, 16'd16000);
    push_sample(OP_DRIVE, 16'd9000, 16'd500, 16'd13000);
    push_sample(OP_DRIVE, -16'sd6000, 16'd500, 16'd15000);
    push_sample(OP_CAPTURE, 16'h0000, 16'h0000, 16'd16384);
    push_sample(OP_DRIVE, 16'd16384, 16'h0000, 16'h0000);
    random_samples(80);
    drain_and_settle();

    set_limit(7'd1);
    random_samples(90);
    drain_and_settle();

    set_limit(7'd90);
    random_samples(90);
    drain_and_settle();

    set_limit(7'($urandom_range(2, 89)));
    random_samples(90);
    drain_and_settle();

    quiet = 1'b1;
    set_limit(7'd30);
    random_samples(90);
    drain_and_settle();

    $display("Covered %0d samples (%0d captures), %0d limit writes, %0d beats checked",
             n_samples, n_captures, n_limits, beats_checked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
